>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the inode cache block.
// Each macro clocks on clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled in reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication that must hold on the clock edge after the trigger.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	`ASSERT_CLK(lbl, (trig) |=> (cons), msg)

`endif

>>> hdl/icfp_pkg.sv
// Shared types and constants for the inode cache frequency policy block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package icfp_pkg;

	// Request modes carried on s_tuser.
	localparam logic [1:0] MODE_GET  = 2'd0;
	localparam logic [1:0] MODE_REL  = 2'd1;
	localparam logic [1:0] MODE_LOOK = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	// Result status codes carried on m_tuser.
	localparam logic [2:0] ST_HIT         = 3'd0;
	localparam logic [2:0] ST_LOADED      = 3'd1;
	localparam logic [2:0] ST_REPLACED    = 3'd2;
	localparam logic [2:0] ST_NONE_FREE   = 3'd3;
	localparam logic [2:0] ST_RELEASED    = 3'd4;
	localparam logic [2:0] ST_WRITTEN     = 3'd5;
	localparam logic [2:0] ST_IGNORED     = 3'd6;
	localparam logic [2:0] ST_LOOKUP_MISS = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PER_BLOCK = 2'd0;
	localparam logic [1:0] CFG_START     = 2'd1;
	localparam logic [1:0] CFG_STRIDE    = 2'd2;

	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam int DIV_STEPS = 32;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LATCH,
		OP_F_RL,
		OP_F_RE,
		OP_F_NEXT,
		OP_HIT,
		OP_MISS,
		OP_FREE_NEXT,
		OP_FILL_FREE,
		OP_R_START,
		OP_R_RE,
		OP_FILL_REPL,
		OP_RM_RD,
		OP_RM_WR,
		OP_RM_END,
		OP_IN_RD,
		OP_SH_START,
		OP_SH_RD,
		OP_SH_WR,
		OP_SH_PUT,
		OP_REL_RD,
		OP_REL_WR,
		OP_IGN,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_OUT
	} op_t;

	// Conditions the datapath reports back to the controller.
	typedef struct packed {
		logic [1:0] mode;
		logic       rel_ok;
		logic       pos_end;
		logic       j_end;
		logic       free_end;
		logic       slot_free;
		logic       key_hit;
		logic       use_sat;
		logic       share_zero;
		logic       use_le;
		logic       sh_end;
		logic       div_done;
		logic       out_busy;
	} stat_t;

endpackage

>>> hdl/icfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the key, share and list stores.
`timescale 1ns / 1ps

module icfp_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// A read of the address being written returns the old data; read data registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/icfp_ctrl.sv
// Sequencer for the inode cache: walks each request through search, fill,
// list reorder, release, divide and output steps. Uses icfp_pkg.
`timescale 1ns / 1ps

module icfp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  icfp_pkg::stat_t    st,
	output icfp_pkg::op_t      op
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_F_RL, S_F_RE, S_F_CK, S_FREE, S_R_RL, S_R_RE, S_R_CK,
		S_RM_RD, S_RM_WR, S_IN_RD, S_IN_CK, S_SH_RD, S_SH_WR, S_REL_RD,
		S_REL_WR, S_IGN, S_DIV0, S_DIV, S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   rdy_q;

	assign s_tready = rdy_q;

	// Next state and the datapath operation for this cycle.
	always_comb begin
		state_d = state_q;
		op = icfp_pkg::OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && rdy_q) begin
					op = icfp_pkg::OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (st.mode)
					icfp_pkg::MODE_GET, icfp_pkg::MODE_LOOK: state_d = S_F_RL;
					icfp_pkg::MODE_REL: state_d = st.rel_ok ? S_REL_RD : S_IGN;
					default: state_d = S_IGN;
				endcase
			end
			S_F_RL: begin
				if (!st.pos_end) begin
					op = icfp_pkg::OP_F_RL;
					state_d = S_F_RE;
				end else if (st.mode == icfp_pkg::MODE_GET) begin
					state_d = S_FREE;
				end else begin
					op = icfp_pkg::OP_MISS;
					state_d = S_OUT;
				end
			end
			S_F_RE: begin
				op = icfp_pkg::OP_F_RE;
				state_d = S_F_CK;
			end
			S_F_CK: begin
				if (st.key_hit) begin
					op = icfp_pkg::OP_HIT;
					if (st.mode == icfp_pkg::MODE_GET && !st.use_sat) begin
						state_d = S_RM_RD;
					end else begin
						state_d = S_DIV0;
					end
				end else begin
					op = icfp_pkg::OP_F_NEXT;
					state_d = S_F_RL;
				end
			end
			S_FREE: begin
				if (st.free_end) begin
					op = icfp_pkg::OP_R_START;
					state_d = S_R_RL;
				end else if (st.slot_free) begin
					op = icfp_pkg::OP_FILL_FREE;
					state_d = S_IN_RD;
				end else begin
					op = icfp_pkg::OP_FREE_NEXT;
				end
			end
			S_R_RL: begin
				if (st.pos_end) begin
					op = icfp_pkg::OP_MISS;
					state_d = S_OUT;
				end else begin
					op = icfp_pkg::OP_F_RL;
					state_d = S_R_RE;
				end
			end
			S_R_RE: begin
				op = icfp_pkg::OP_R_RE;
				state_d = S_R_CK;
			end
			S_R_CK: begin
				if (st.share_zero) begin
					op = icfp_pkg::OP_FILL_REPL;
					state_d = S_RM_RD;
				end else begin
					op = icfp_pkg::OP_F_NEXT;
					state_d = S_R_RL;
				end
			end
			S_RM_RD: begin
				if (st.j_end) begin
					op = icfp_pkg::OP_RM_END;
					state_d = S_IN_RD;
				end else begin
					op = icfp_pkg::OP_RM_RD;
					state_d = S_RM_WR;
				end
			end
			S_RM_WR: begin
				op = icfp_pkg::OP_RM_WR;
				state_d = S_RM_RD;
			end
			S_IN_RD: begin
				if (st.pos_end) begin
					op = icfp_pkg::OP_SH_START;
					state_d = S_SH_RD;
				end else begin
					op = icfp_pkg::OP_IN_RD;
					state_d = S_IN_CK;
				end
			end
			S_IN_CK: begin
				if (st.use_le) begin
					op = icfp_pkg::OP_F_NEXT;
					state_d = S_IN_RD;
				end else begin
					op = icfp_pkg::OP_SH_START;
					state_d = S_SH_RD;
				end
			end
			S_SH_RD: begin
				if (st.sh_end) begin
					op = icfp_pkg::OP_SH_PUT;
					state_d = S_DIV0;
				end else begin
					op = icfp_pkg::OP_SH_RD;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				op = icfp_pkg::OP_SH_WR;
				state_d = S_SH_RD;
			end
			S_REL_RD: begin
				op = icfp_pkg::OP_REL_RD;
				state_d = S_REL_WR;
			end
			S_REL_WR: begin
				op = icfp_pkg::OP_REL_WR;
				state_d = S_DIV0;
			end
			S_IGN: begin
				op = icfp_pkg::OP_IGN;
				state_d = S_OUT;
			end
			S_DIV0: begin
				op = icfp_pkg::OP_DIV_START;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) begin
					state_d = S_OUT;
				end else begin
					op = icfp_pkg::OP_DIV_STEP;
				end
			end
			S_OUT: begin
				if (!st.out_busy) begin
					op = icfp_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register and the registered ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q <= 1'b1;
		end else begin
			state_q <= state_d;
			rdy_q <= (state_d == S_IDLE);
		end
	end

endmodule

>>> hdl/icfp_dp.sv
// Datapath of the inode cache: entry stores, ordered use list, counters,
// block/slot divider and output register. Uses icfp_pkg and icfp_ram.
`timescale 1ns / 1ps

module icfp_dp #(
	parameter int ENTRIES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [47:0]      s_tdata,
	input  logic [1:0]       s_tuser,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [23:0]      cfg_data,
	input  icfp_pkg::op_t    op,
	output icfp_pkg::stat_t  st,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [167:0]     m_tdata,
	output logic [2:0]       m_tuser
);

	localparam int EW = $clog2(ENTRIES);
	localparam int PW = $clog2(ENTRIES + 1);
	localparam int LW = 16 + EW;

	// Latched request.
	logic [1:0]  mode_q;
	logic [3:0]  dev_q;
	logic [31:0] ino_q;
	logic [5:0]  idx_q;
	logic        md_q;

	// Walk pointers and working entry.
	logic [PW-1:0] pos_q, j_q, cached_q, jm1;
	logic [EW-1:0] ent_q, idx_ew;
	logic [15:0]   use_q, thr_q;
	logic [ENTRIES-1:0] valid_q;
	logic [31:0] req_q, hit_q;

	// Result being built.
	logic [2:0]  status_q;
	logic        load_q, wb_q, rep_q;
	logic [3:0]  rep_dev_q;
	logic [31:0] rep_ino_q;
	logic [15:0] rep_share_q;

	// Divider.
	logic [31:0] dq_q;
	logic [6:0]  rem_q, pbc;
	logic [5:0]  dcnt_q;
	logic [7:0]  r2;

	// Configuration.
	logic [6:0]  ipb_q;
	logic [23:0] start_q;
	logic [3:0]  stride_q, stc;

	// Output register.
	logic         m_valid_q;
	logic [167:0] m_data_q;
	logic [2:0]   m_user_q;

	// Store ports.
	logic          list_we, key_we, sh_we;
	logic [EW-1:0] list_raddr, list_waddr, ent_raddr, key_waddr, sh_waddr;
	logic [LW-1:0] list_rd, list_wd;
	logic [35:0]   key_rd;
	logic [16:0]   sh_rd, sh_wd;
	logic [15:0]   list_rd_use, hit_share, rel_s, rel_sn;
	logic [EW-1:0] list_rd_ent;
	logic          rel_d, rel_wb, idx_ok;

	// Result fields before packing.
	logic [5:0]  o_ent;
	logic [15:0] o_share;
	logic [3:0]  o_dev;
	logic [31:0] o_ino, o_block;
	logic [8:0]  o_slot;

	assign idx_ew      = EW'(idx_q);
	assign jm1         = j_q - 1'b1;
	assign list_rd_use = list_rd[LW-1:EW];
	assign list_rd_ent = list_rd[EW-1:0];
	assign idx_ok      = (32'(idx_q) < ENTRIES);

	// Clamped configuration values.
	assign pbc = (ipb_q == 7'd0) ? 7'd1 : ((ipb_q > 7'd64) ? 7'd64 : ipb_q);
	assign stc = (stride_q == 4'd0) ? 4'd1 : ((stride_q > 4'd8) ? 4'd8 : stride_q);
	assign r2  = {rem_q, dq_q[31]};

	// Saturating share increment and release arithmetic.
	assign hit_share = (sh_rd[15:0] != icfp_pkg::CNT_MAX) ? sh_rd[15:0] + 16'd1
	                                                      : sh_rd[15:0];
	assign rel_d  = sh_rd[16] | md_q;
	assign rel_s  = sh_rd[15:0];
	assign rel_sn = (rel_s != 16'd0) ? rel_s - 16'd1 : 16'd0;
	assign rel_wb = (rel_sn == 16'd0) && rel_d;

	// Status back to the controller.
	always_comb begin
		st.mode       = mode_q;
		st.rel_ok     = idx_ok && valid_q[idx_ew];
		st.pos_end    = (pos_q >= cached_q);
		st.j_end      = (j_q >= cached_q);
		st.free_end   = (j_q == PW'(ENTRIES));
		st.slot_free  = !valid_q[j_q[EW-1:0]];
		st.key_hit    = (key_rd == {dev_q, ino_q});
		st.use_sat    = (use_q == icfp_pkg::CNT_MAX);
		st.share_zero = (sh_rd[15:0] == 16'd0);
		st.use_le     = (list_rd_use <= thr_q);
		st.sh_end     = (j_q == pos_q);
		st.div_done   = (dcnt_q == 6'(icfp_pkg::DIV_STEPS));
		st.out_busy   = m_valid_q && !m_tready;
	end

	// Store address and write selection.
	always_comb begin
		case (op)
			icfp_pkg::OP_RM_RD: list_raddr = j_q[EW-1:0];
			icfp_pkg::OP_SH_RD: list_raddr = jm1[EW-1:0];
			default:            list_raddr = pos_q[EW-1:0];
		endcase
		ent_raddr = (op == icfp_pkg::OP_REL_RD) ? idx_ew : list_rd_ent;

		list_we = (op == icfp_pkg::OP_RM_WR) || (op == icfp_pkg::OP_SH_WR) ||
		          (op == icfp_pkg::OP_SH_PUT);
		case (op)
			icfp_pkg::OP_RM_WR: list_waddr = jm1[EW-1:0];
			icfp_pkg::OP_SH_WR: list_waddr = j_q[EW-1:0];
			default:            list_waddr = pos_q[EW-1:0];
		endcase
		list_wd = (op == icfp_pkg::OP_SH_PUT) ? {use_q, ent_q} : list_rd;

		key_we = (op == icfp_pkg::OP_FILL_FREE) || (op == icfp_pkg::OP_FILL_REPL);
		key_waddr = (op == icfp_pkg::OP_FILL_FREE) ? j_q[EW-1:0] : ent_q;

		sh_we = key_we || (op == icfp_pkg::OP_HIT) || (op == icfp_pkg::OP_REL_WR);
		case (op)
			icfp_pkg::OP_FILL_FREE: sh_waddr = j_q[EW-1:0];
			icfp_pkg::OP_REL_WR:    sh_waddr = idx_ew;
			default:                sh_waddr = ent_q;
		endcase
		case (op)
			icfp_pkg::OP_HIT:    sh_wd = {sh_rd[16], hit_share};
			icfp_pkg::OP_REL_WR: sh_wd = {rel_d & !rel_wb, rel_sn};
			default:             sh_wd = {1'b0, 16'd1};
		endcase
	end

	// Use list by position: use count above, entry number below.
	icfp_ram #(.W(LW), .D(ENTRIES)) list_ram (
		.clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wd),
		.raddr(list_raddr), .rdata(list_rd)
	);

	// Device and inode number by entry.
	icfp_ram #(.W(36), .D(ENTRIES)) key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata({dev_q, ino_q}),
		.raddr(ent_raddr), .rdata(key_rd)
	);

	// Dirty mark and share count by entry.
	icfp_ram #(.W(17), .D(ENTRIES)) share_ram (
		.clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wd),
		.raddr(ent_raddr), .rdata(sh_rd)
	);

	// Result fields; those of unreported results read as zero, but for the entry index of an ignored request.
	always_comb begin
		if (rep_q) begin
			o_ent   = 6'(ent_q);
			o_share = rep_share_q;
			o_dev   = rep_dev_q;
			o_ino   = rep_ino_q;
			o_block = dq_q + 32'(start_q);
			o_slot  = 9'(rem_q) * 9'(stc);
		end else begin
			o_ent   = (status_q == icfp_pkg::ST_IGNORED) ? idx_q : 6'd0;
			o_share = 16'd0;
			o_dev   = 4'd0;
			o_ino   = 32'd0;
			o_block = 32'd0;
			o_slot  = 9'd0;
		end
	end

	// Control registers: pointers, valid bits, totals, divider count, configuration, output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			j_q       <= '0;
			cached_q  <= '0;
			valid_q   <= '0;
			req_q     <= '0;
			hit_q     <= '0;
			dcnt_q    <= '0;
			m_valid_q <= 1'b0;
			ipb_q     <= 7'd8;
			start_q   <= 24'd10;
			stride_q  <= 4'd1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					icfp_pkg::CFG_PER_BLOCK: ipb_q <= cfg_data[6:0];
					icfp_pkg::CFG_START:     start_q <= cfg_data;
					icfp_pkg::CFG_STRIDE:    stride_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (op == icfp_pkg::OP_OUT) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (op)
				icfp_pkg::OP_LATCH: begin
					pos_q <= '0;
					j_q <= '0;
					if (s_tuser == icfp_pkg::MODE_GET) begin
						req_q <= req_q + 32'd1;
					end
				end
				icfp_pkg::OP_F_NEXT: pos_q <= pos_q + 1'b1;
				icfp_pkg::OP_HIT: begin
					if (mode_q == icfp_pkg::MODE_GET) begin
						hit_q <= hit_q + 32'd1;
					end
					j_q <= pos_q + 1'b1;
				end
				icfp_pkg::OP_FREE_NEXT: j_q <= j_q + 1'b1;
				icfp_pkg::OP_FILL_FREE: begin
					valid_q[j_q[EW-1:0]] <= 1'b1;
					pos_q <= '0;
				end
				icfp_pkg::OP_R_START: pos_q <= '0;
				icfp_pkg::OP_FILL_REPL: j_q <= pos_q + 1'b1;
				icfp_pkg::OP_RM_WR: j_q <= j_q + 1'b1;
				icfp_pkg::OP_RM_END: begin
					cached_q <= cached_q - 1'b1;
					pos_q <= '0;
				end
				icfp_pkg::OP_SH_START: j_q <= cached_q;
				icfp_pkg::OP_SH_WR: j_q <= jm1;
				icfp_pkg::OP_SH_PUT: cached_q <= cached_q + 1'b1;
				icfp_pkg::OP_DIV_START: dcnt_q <= '0;
				icfp_pkg::OP_DIV_STEP: dcnt_q <= dcnt_q + 6'd1;
				default: ;
			endcase
		end
	end

	// Payload registers: request fields, working entry, result, divider.
	always_ff @(posedge clk) begin
		case (op)
			icfp_pkg::OP_LATCH: begin
				mode_q <= s_tuser;
				dev_q  <= s_tdata[3:0];
				ino_q  <= s_tdata[35:4];
				idx_q  <= s_tdata[41:36];
				md_q   <= s_tdata[42];
				load_q <= 1'b0;
				wb_q   <= 1'b0;
				rep_q  <= 1'b0;
			end
			icfp_pkg::OP_F_RE: begin
				ent_q <= list_rd_ent;
				use_q <= list_rd_use;
			end
			icfp_pkg::OP_HIT: begin
				status_q    <= icfp_pkg::ST_HIT;
				rep_q       <= 1'b1;
				rep_dev_q   <= key_rd[35:32];
				rep_ino_q   <= key_rd[31:0];
				rep_share_q <= hit_share;
				thr_q       <= use_q;
				if (use_q != icfp_pkg::CNT_MAX) begin
					use_q <= use_q + 16'd1;
				end
			end
			icfp_pkg::OP_MISS: begin
				status_q <= (mode_q == icfp_pkg::MODE_GET) ? icfp_pkg::ST_NONE_FREE
				                                           : icfp_pkg::ST_LOOKUP_MISS;
				rep_q <= 1'b0;
			end
			icfp_pkg::OP_FILL_FREE, icfp_pkg::OP_FILL_REPL: begin
				if (op == icfp_pkg::OP_FILL_FREE) begin
					ent_q    <= j_q[EW-1:0];
					status_q <= icfp_pkg::ST_LOADED;
				end else begin
					status_q <= icfp_pkg::ST_REPLACED;
				end
				load_q      <= 1'b1;
				rep_q       <= 1'b1;
				rep_dev_q   <= dev_q;
				rep_ino_q   <= ino_q;
				rep_share_q <= 16'd1;
				use_q       <= 16'd1;
				thr_q       <= 16'd1;
			end
			icfp_pkg::OP_R_RE: ent_q <= list_rd_ent;
			icfp_pkg::OP_REL_WR: begin
				ent_q       <= idx_ew;
				rep_q       <= 1'b1;
				rep_dev_q   <= key_rd[35:32];
				rep_ino_q   <= key_rd[31:0];
				rep_share_q <= rel_sn;
				wb_q        <= rel_wb;
				status_q    <= rel_wb ? icfp_pkg::ST_WRITTEN : icfp_pkg::ST_RELEASED;
			end
			icfp_pkg::OP_IGN: begin
				status_q <= icfp_pkg::ST_IGNORED;
				rep_q    <= 1'b0;
			end
			icfp_pkg::OP_DIV_START: begin
				dq_q  <= rep_ino_q - 32'd1;
				rem_q <= 7'd0;
			end
			icfp_pkg::OP_DIV_STEP: begin
				// One restoring step: quotient bit enters from the right.
				if (r2 >= {1'b0, pbc}) begin
					rem_q <= 7'(r2 - {1'b0, pbc});
					dq_q  <= {dq_q[30:0], 1'b1};
				end else begin
					rem_q <= r2[6:0];
					dq_q  <= {dq_q[30:0], 1'b0};
				end
			end
			icfp_pkg::OP_OUT: begin
				m_user_q <= status_q;
				m_data_q <= {3'b000, hit_q, req_q, o_slot, o_block, o_ino, o_dev,
				             wb_q, load_q, o_share, o_ent};
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

>>> hdl/inode_cache_frequency_policy.sv
// Inode cache with use-count ordered replacement. One request is taken at a
// time: s_tready drops after each accepted beat and returns once its result
// beat is in the output register. A request steps through the key walk, the
// free-slot sweep, the list reorder when the use list changes, and the
// one-bit-per-cycle divider that forms the block and slot (a start step, 32
// steps and a done check). Its speed is set by the single read port of each
// entry store. No clearing pass is needed after reset: entry valid bits
// reset at once.
// Depends on icfp_pkg, icfp_ctrl, icfp_dp and icfp_ram.
`timescale 1ns / 1ps

module inode_cache_frequency_policy #(
	parameter int ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// device[3:0], inode_number[35:4], entry_index[41:36], mark_dirty[42]
	input  logic [47:0]  s_tdata,
	// mode[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_entry[5:0], share_count_now[21:6], load_needed[22],
	// writeback_needed[23], out_device[27:24], out_inode[59:28],
	// inode_block[91:60], inode_slot[100:92], total_requests[132:101],
	// total_hits[164:133]
	output logic [167:0] m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	icfp_pkg::op_t   op;
	icfp_pkg::stat_t st;

	// Sequencer.
	icfp_ctrl ctrl_i (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.st(st), .op(op)
	);

	// Stores, counters, divider and output register.
	icfp_dp #(.ENTRIES(ENTRIES)) dp_i (
		.clk(clk), .arst_n(arst_n), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .st(st), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

>>> hdl/icfp_chk.sv
// Port-level checks for the inode cache block, bound to the top level.
// Depends on icfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module icfp_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [167:0] m_tdata,
	input logic [2:0]   m_tuser
);

	logic load_ok, wb_ok;

	// Flags that the status of a result beat calls for.
	assign load_ok = (m_tdata[22] == ((m_tuser == icfp_pkg::ST_LOADED) ||
	                                  (m_tuser == icfp_pkg::ST_REPLACED)));
	assign wb_ok   = (m_tdata[23] == (m_tuser == icfp_pkg::ST_WRITTEN));

	// A waiting result beat is held.
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
	`ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result beat changed")

	// One request at a time: the input closes after each accepted beat.
	`ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second beat taken early")

	// Load and write-back requests agree with the status.
	`ASSERT_CLK(a_load_status, m_tvalid |-> load_ok, "load flag disagrees with status")
	`ASSERT_CLK(a_wb_status, m_tvalid |-> wb_ok, "write-back flag disagrees with status")

endmodule

bind inode_cache_frequency_policy icfp_chk chk_i (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

>>> bench/tb_inode_cache_frequency_policy.sv
// Self-checking bench for the inode cache frequency policy block.
// A built-in predictor mirrors the entry table, the use-ordered list and the totals.
// Depends on icfp_pkg and the inode_cache_frequency_policy RTL.
`timescale 1ns / 1ps

module tb_inode_cache_frequency_policy;

	localparam int NENT = 64;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  entry;
		logic [15:0] share;
		logic        load;
		logic        wb;
		logic [3:0]  dev;
		logic [31:0] ino;
		logic [31:0] blk;
		logic [8:0]  slot;
		logic [31:0] req_total;
		logic [31:0] hit_total;
	} cache_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [167:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [23:0]  cfg_data;

	inode_cache_frequency_policy #(.ENTRIES(NENT)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Predicted cache state.
	logic [6:0]  per_block_reg;
	logic [23:0] table_start_reg;
	logic [3:0]  stride_reg;
	logic        in_cache [NENT];
	logic [3:0]  ent_dev [NENT];
	logic [31:0] ent_ino [NENT];
	logic [15:0] use_cnt [NENT];
	logic [15:0] share_cnt [NENT];
	logic        dirty [NENT];
	int          lst [NENT];
	int          n_cached;
	logic [31:0] req_count;
	logic [31:0] hit_count;

	cache_result_t expected_results[$];
	int  mismatches;
	bit  idle_on;
	bit  hold_req;
	int  quiet_cycles;

	function automatic void list_remove(int pos);
		for (int i = pos; i < n_cached - 1; i++) lst[i] = lst[i + 1];
		n_cached--;
	endfunction

	function automatic void list_insert(int pos, int e);
		for (int i = n_cached; i > pos; i--) lst[i] = lst[i - 1];
		lst[pos] = e;
		n_cached++;
	endfunction

	function automatic int find_key(logic [3:0] dv, logic [31:0] ino);
		for (int p = 0; p < n_cached; p++)
			if (ent_dev[lst[p]] == dv && ent_ino[lst[p]] == ino) return p;
		return n_cached;
	endfunction

	// A newly filled entry goes behind every entry whose use count is one or less.
	function automatic void fill_and_enqueue(int e, logic [3:0] dv, logic [31:0] ino);
		int p;
		p = 0;
		in_cache[e] = 1'b1;
		ent_dev[e] = dv;
		ent_ino[e] = ino;
		use_cnt[e] = 16'd1;
		share_cnt[e] = 16'd1;
		dirty[e] = 1'b0;
		while (p < n_cached && use_cnt[lst[p]] <= 16'd1) p++;
		list_insert(p, e);
	endfunction

	function automatic void reset_cache_model();
		per_block_reg = 7'd8;
		table_start_reg = 24'd10;
		stride_reg = 4'd1;
		for (int i = 0; i < NENT; i++) begin
			in_cache[i] = 1'b0;
			use_cnt[i] = '0;
			share_cnt[i] = '0;
			dirty[i] = 1'b0;
		end
		n_cached = 0;
		req_count = '0;
		hit_count = '0;
	endfunction

	// Works out the result beat for one request and updates the predicted state.
	function automatic cache_result_t predict_cache_step(logic [1:0] mode, logic [3:0] dv,
			logic [31:0] ino, logic [5:0] idx, logic md);
		cache_result_t r;
		bit report;
		int e, p, i;
		logic [31:0] k, pb, st;
		r = '0;
		report = 0;
		e = 0;
		r.status = icfp_pkg::ST_IGNORED;
		case (mode)
			icfp_pkg::MODE_GET: begin
				req_count++;
				p = find_key(dv, ino);
				if (p < n_cached) begin
					e = lst[p];
					hit_count++;
					if (share_cnt[e] != icfp_pkg::CNT_MAX) share_cnt[e]++;
					if (use_cnt[e] != icfp_pkg::CNT_MAX) begin
						use_cnt[e]++;
						list_remove(p);
						p = 0;
						while (p < n_cached && use_cnt[lst[p]] < use_cnt[e]) p++;
						list_insert(p, e);
					end
					r.status = icfp_pkg::ST_HIT;
					report = 1;
				end else begin
					i = 0;
					while (i < NENT && in_cache[i]) i++;
					if (i < NENT) begin
						e = i;
						fill_and_enqueue(e, dv, ino);
						r.status = icfp_pkg::ST_LOADED;
						r.load = 1'b1;
						report = 1;
					end else begin
						p = 0;
						while (p < n_cached && share_cnt[lst[p]] != 0) p++;
						if (p < n_cached) begin
							e = lst[p];
							list_remove(p);
							fill_and_enqueue(e, dv, ino);
							r.status = icfp_pkg::ST_REPLACED;
							r.load = 1'b1;
							report = 1;
						end else begin
							r.status = icfp_pkg::ST_NONE_FREE;
						end
					end
				end
			end
			icfp_pkg::MODE_REL: begin
				r.entry = idx;
				if (in_cache[idx]) begin
					e = idx;
					if (md) dirty[e] = 1'b1;
					if (share_cnt[e] != 0) share_cnt[e]--;
					if (share_cnt[e] == 0 && dirty[e]) begin
						dirty[e] = 1'b0;
						r.wb = 1'b1;
						r.status = icfp_pkg::ST_WRITTEN;
					end else begin
						r.status = icfp_pkg::ST_RELEASED;
					end
					report = 1;
				end
			end
			icfp_pkg::MODE_LOOK: begin
				p = find_key(dv, ino);
				if (p < n_cached) begin
					e = lst[p];
					if (share_cnt[e] != icfp_pkg::CNT_MAX) share_cnt[e]++;
					r.status = icfp_pkg::ST_HIT;
					report = 1;
				end else begin
					r.status = icfp_pkg::ST_LOOKUP_MISS;
				end
			end
			default: r.entry = idx;
		endcase
		if (report) begin
			pb = per_block_reg;
			st = stride_reg;
			if (pb < 1) pb = 1;
			if (pb > 64) pb = 64;
			if (st < 1) st = 1;
			if (st > 8) st = 8;
			k = ent_ino[e] - 32'd1;
			r.entry = e[5:0];
			r.share = share_cnt[e];
			r.dev = ent_dev[e];
			r.ino = ent_ino[e];
			r.blk = k / pb + {8'd0, table_start_reg};
			r.slot = 9'((k % pb) * st);
		end
		r.req_total = req_count;
		r.hit_total = hit_count;
		return r;
	endfunction

	// Offers one request beat and waits for it to be taken.
	task automatic send_request(logic [1:0] mode, logic [3:0] dv, logic [31:0] ino,
			logic [5:0] idx, logic md);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'd0, md, idx, ino, dv};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_cache_step(mode, dv, ino, idx, md));
	endtask

	// Random request drawn from a small key pool so that hits and replacements are common.
	task automatic send_random(int pool);
		logic [1:0] mode;
		logic [3:0] dv;
		logic [31:0] ino;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) mode = icfp_pkg::MODE_GET;
		else if (pick < 80) mode = icfp_pkg::MODE_REL;
		else if (pick < 95) mode = icfp_pkg::MODE_LOOK;
		else mode = icfp_pkg::MODE_NONE;
		if ($urandom_range(0, 19) == 0) begin
			dv = 4'($urandom);
			ino = $urandom;
		end else begin
			dv = 4'($urandom_range(0, 3));
			ino = 32'($urandom_range(0, pool));
		end
		send_request(mode, dv, ino, 6'($urandom), 1'($urandom_range(0, 2) == 0));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			icfp_pkg::CFG_PER_BLOCK: per_block_reg = val[6:0];
			icfp_pkg::CFG_START:     table_start_reg = val;
			default:                 stride_reg = val[3:0];
		endcase
	endtask

	task automatic test_directed();
		send_request(icfp_pkg::MODE_GET, 4'd0, 32'd1, 6'd0, 1'b0);
		send_request(icfp_pkg::MODE_GET, 4'd15, 32'hFFFF_FFFF, 6'd63, 1'b1);
		send_request(icfp_pkg::MODE_GET, 4'd3, 32'd0, 6'd0, 1'b0);
		send_request(icfp_pkg::MODE_GET, 4'd0, 32'd1, 6'd0, 1'b0);
		send_request(icfp_pkg::MODE_LOOK, 4'd15, 32'hFFFF_FFFF, 6'd0, 1'b0);
		send_request(icfp_pkg::MODE_LOOK, 4'd7, 32'd12345, 6'd0, 1'b0);
		// Dirty release while shared, then down to zero with write-back.
		send_request(icfp_pkg::MODE_REL, 4'd0, 32'd0, 6'd1, 1'b1);
		send_request(icfp_pkg::MODE_REL, 4'd0, 32'd0, 6'd1, 1'b0);
		// Release at share count zero, clean then dirty.
		send_request(icfp_pkg::MODE_REL, 4'd0, 32'd0, 6'd1, 1'b0);
		send_request(icfp_pkg::MODE_REL, 4'd0, 32'd0, 6'd1, 1'b1);
		send_request(icfp_pkg::MODE_REL, 4'd0, 32'd0, 6'd63, 1'b1);
		send_request(icfp_pkg::MODE_NONE, 4'd9, 32'hA5A5_5A5A, 6'd42, 1'b1);
		send_request(icfp_pkg::MODE_GET, 4'd1, 32'd1, 6'd0, 1'b0);
		send_request(icfp_pkg::MODE_GET, 4'd0, 32'd1, 6'd0, 1'b0);
	endtask

	// Fill every entry, run out of idle ones, then free some and force replacement.
	task automatic test_fill_replace();
		for (int i = 0; i < NENT + 2; i++)
			send_request(icfp_pkg::MODE_GET, 4'd2, 32'(1000 + i), 6'd0, 1'b0);
		for (int i = 0; i < 6; i++) begin
			send_request(icfp_pkg::MODE_REL, 4'd0, 32'd0, 6'(i * 9), 1'b1);
			send_request(icfp_pkg::MODE_REL, 4'd0, 32'd0, 6'(i * 9), 1'b0);
		end
		for (int i = 0; i < 8; i++)
			send_request(icfp_pkg::MODE_GET, 4'd5, 32'(2000 + i), 6'd0, 1'b0);
	endtask

	task automatic test_config();
		logic [23:0] per_b [5] = '{24'd1, 24'd64, 24'd0, 24'd127, 24'd3};
		logic [23:0] start [5] = '{24'd0, 24'hFFFFFF, 24'd77, 24'hABCDEF, 24'd12345};
		logic [23:0] strd [5] = '{24'd1, 24'd8, 24'd0, 24'd15, 24'd5};
		for (int s = 0; s < 5; s++) begin
			write_reg(icfp_pkg::CFG_PER_BLOCK, per_b[s]);
			write_reg(icfp_pkg::CFG_START, start[s]);
			write_reg(icfp_pkg::CFG_STRIDE, strd[s]);
			for (int i = 0; i < 30; i++) send_random(60);
		end
		write_reg(icfp_pkg::CFG_PER_BLOCK, 24'd8);
		write_reg(icfp_pkg::CFG_START, 24'd10);
		write_reg(icfp_pkg::CFG_STRIDE, 24'd1);
	endtask

	// Receiver holds off while requests keep coming, so the block stalls its input.
	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++) send_random(80);
	endtask

	task automatic test_random();
		for (int i = 0; i < 1500; i++) send_random((i / 300) % 2 == 0 ? 90 : 200);
		idle_on = 1'b0;
		for (int i = 0; i < 200; i++) send_random(90);
	endtask

	// Result side: random stall bursts and the long hold-off.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		cache_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[5:0], m_tdata[21:6], m_tdata[22], m_tdata[23],
				m_tdata[27:24], m_tdata[59:28], m_tdata[91:60], m_tdata[100:92],
				m_tdata[132:101], m_tdata[164:133]};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.entry !== want.entry ||
						got.share !== want.share || got.load !== want.load ||
						got.wb !== want.wb || got.dev !== want.dev || got.ino !== want.ino ||
						got.blk !== want.blk || got.slot !== want.slot ||
						got.req_total !== want.req_total ||
						got.hit_total !== want.hit_total) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t\n  expected %p\n  actual   %p",
							$realtime, want, got);
				end
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_inode_cache_frequency_policy: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		mismatches = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		reset_cache_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_replace();
		test_backpressure();
		test_config();
		test_random();
		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb_inode_cache_frequency_policy: PASS");
		else
			$display("tb_inode_cache_frequency_policy: FAIL");
		$finish;
	end

endmodule
